@@ hdl/tkh_pkg.sv @@
// ----------------------------------------------------------------------------
// tkh_pkg
// Shared constants, types and helpers of the top-k tracker: entry widths,
// circular slot addressing and keep count clamping.
// ----------------------------------------------------------------------------
package tkh_pkg;

   // built capacity of the entry store
   localparam int CAPACITY = 16;
   localparam int ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   // field widths
   localparam int TAG_W   = 16;
   localparam int COUNT_W = 30;
   localparam int KEY_W   = COUNT_W + TAG_W;
   localparam int KEEP_W  = 5;

   localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;
   localparam logic [CNT_W:0]    CAP_SUM    = (CNT_W + 1)'(CAPACITY);
   localparam logic [CNT_W-1:0]  CAP_CNT    = CNT_W'(CAPACITY);

   // command codes
   localparam logic CMD_REGISTER = 1'b0;
   localparam logic CMD_READ     = 1'b1;

   // one access to the entry memory
   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
      logic [ADDR_W-1:0] rd_addr;
   } mem_req_type;

   // one result toward the output stage
   typedef struct packed {
      logic               valid;
      logic               found;
      logic [TAG_W-1:0]   tag;
      logic [COUNT_W-1:0] count;
      logic               last;
   } rsp_type;

   // memory slot of the entry at rank off above the oldest slot base
   function automatic logic [ADDR_W-1:0] slot_addr(input logic [ADDR_W-1:0] base,
                                                  input logic [CNT_W-1:0]  off);
      logic [CNT_W:0] sum;
      sum = {1'b0, off} + (CNT_W + 1)'(base);
      if (sum >= CAP_SUM) begin
         sum = sum - CAP_SUM;
      end
      return ADDR_W'(sum);
   endfunction

   // clamp the keep count to one at the low end and the capacity at the top
   function automatic logic [CNT_W-1:0] eff_keep(input logic [KEEP_W-1:0] keep);
      logic [CNT_W-1:0] k;
      if (keep == '0) begin
         k = CNT_W'(1);
      end else if (int'(keep) > CAPACITY) begin
         k = CAP_CNT;
      end else begin
         k = CNT_W'(keep);
      end
      return k;
   endfunction

endpackage

@@ hdl/tkh_ram.sv @@
// ----------------------------------------------------------------------------
// tkh_ram
// Simple dual port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tkh_ram #(
   parameter int Depth     = 16,
   parameter int Width     = 46,
   parameter int AddrWidth = 4
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AddrWidth-1:0] wr_addr,
   input  logic [Width-1:0]     wr_data,
   input  logic [AddrWidth-1:0] rd_addr,
   output logic [Width-1:0]     rd_data
);

   logic [Width-1:0] mem [Depth];
   logic [Width-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered read data
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/tkh_seq.sv @@
// ----------------------------------------------------------------------------
// tkh_seq
// Sequencer of the top-k tracker. Entries sit sorted ascending in a circular
// window of the entry memory starting at base. Dropping the smallest entry
// advances base; an insert shifts larger entries up one slot per cycle.
// ----------------------------------------------------------------------------
module tkh_seq import tkh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [TAG_W-1:0]   req_title_tag,
   input  logic [COUNT_W-1:0] req_play_count,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [KEEP_W-1:0]  csr_keep_count,
   input  logic [KEY_W-1:0]   rd_data,
   output mem_req_type        mem_req,
   output rsp_type            rsp
);

   typedef enum logic [2:0] {
      IDLE,
      CHECK_MIN,
      SHIFT_START,
      SHIFT,
      PLACE,
      READOUT
   } state_type;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  held_ff, held_in;
   logic [ADDR_W-1:0] base_ff, base_in;
   logic [KEEP_W-1:0] keep_ff, keep_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [CNT_W-1:0]  issue_ff, issue_in;
   logic              pend_ff, pend_in;
   logic              pend_last_ff, pend_last_in;

   logic [CNT_W-1:0]  eff;
   logic [CNT_W-1:0]  new_eff;

   assign eff     = eff_keep(keep_ff);
   assign new_eff = eff_keep(csr_keep_count);

   assign busy      = (state_ff != IDLE);
   assign csr_ready = (state_ff == IDLE) && !start;

   // next state, memory access and result
   always_comb begin
      state_in     = state_ff;
      held_in      = held_ff;
      base_in      = base_ff;
      keep_in      = keep_ff;
      key_in       = key_ff;
      idx_in       = idx_ff;
      issue_in     = issue_ff;
      pend_in      = 1'b0;
      pend_last_in = pend_last_ff;
      mem_req      = '0;
      rsp          = '0;

      unique case (state_ff)
         IDLE: begin
            if (start) begin
               if (req_command == CMD_REGISTER) begin
                  key_in = {req_play_count, req_title_tag};
                  if (held_ff < eff) begin
                     state_in = SHIFT_START;
                  end else begin
                     // full: fetch the smallest entry to compare against
                     mem_req.rd_addr = base_ff;
                     state_in        = CHECK_MIN;
                  end
               end else if (held_ff == '0) begin
                  rsp.valid = 1'b1;
                  rsp.found = 1'b0;
                  rsp.last  = 1'b1;
               end else begin
                  issue_in = '0;
                  state_in = READOUT;
               end
            end else if (csr_valid) begin
               // apply new keep count, drop the smallest surplus entries
               keep_in = csr_keep_count;
               if (held_ff > new_eff) begin
                  base_in = slot_addr(base_ff, held_ff - new_eff);
                  held_in = new_eff;
               end
            end
         end

         CHECK_MIN: begin
            if (key_ff > rd_data) begin
               base_in  = slot_addr(base_ff, CNT_W'(1));
               held_in  = held_ff - CNT_W'(1);
               state_in = SHIFT_START;
            end else begin
               state_in = IDLE;
            end
         end

         SHIFT_START: begin
            idx_in = held_ff;
            if (held_ff == '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = base_ff;
               mem_req.wr_data = key_ff;
               held_in         = held_ff + CNT_W'(1);
               state_in        = IDLE;
            end else begin
               mem_req.rd_addr = slot_addr(base_ff, held_ff - CNT_W'(1));
               state_in        = SHIFT;
            end
         end

         SHIFT: begin
            if (rd_data > key_ff) begin
               // move the larger entry up and fetch the next one down
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = slot_addr(base_ff, idx_ff);
               mem_req.wr_data = rd_data;
               idx_in          = idx_ff - CNT_W'(1);
               if (idx_ff == CNT_W'(1)) begin
                  state_in = PLACE;
               end else begin
                  mem_req.rd_addr = slot_addr(base_ff, idx_ff - CNT_W'(2));
               end
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = slot_addr(base_ff, idx_ff);
               mem_req.wr_data = key_ff;
               held_in         = held_ff + CNT_W'(1);
               state_in        = IDLE;
            end
         end

         PLACE: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = slot_addr(base_ff, idx_ff);
            mem_req.wr_data = key_ff;
            held_in         = held_ff + CNT_W'(1);
            state_in        = IDLE;
         end

         READOUT: begin
            // issue one read per cycle, emit the data in the cycle after its read
            if (issue_ff < held_ff) begin
               mem_req.rd_addr = slot_addr(base_ff, issue_ff);
               issue_in        = issue_ff + CNT_W'(1);
               pend_in         = 1'b1;
               pend_last_in    = (issue_ff == held_ff - CNT_W'(1));
            end
            if (pend_ff) begin
               rsp.valid = 1'b1;
               rsp.found = 1'b1;
               rsp.tag   = rd_data[TAG_W-1:0];
               rsp.count = rd_data[KEY_W-1:TAG_W];
               rsp.last  = pend_last_ff;
               if (pend_last_ff) begin
                  state_in = IDLE;
               end
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         held_ff      <= '0;
         base_ff      <= '0;
         keep_ff      <= KEEP_RESET;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         issue_ff     <= '0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         base_ff      <= base_in;
         keep_ff      <= keep_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         issue_ff     <= issue_in;
         idx_ff       <= idx_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

endmodule

@@ hdl/top_k_tracker_min_heap.sv @@
// ----------------------------------------------------------------------------
// top_k_tracker_min_heap
// Keeps the keep_count largest (count, tag) entries seen so far and reads
// them out in ascending order.
//
//   channel   ports                                handshake
//   request   start, busy, req_*                   start high while busy low
//   result    rsp_strobe, rsp_*                    one cycle strobe, no stall
//   config    csr_valid, csr_ready, csr_keep_count valid and ready
//
// A register transfer first reads the smallest entry when the store is full
// and drops it if the new key is larger, else ends; it then shifts each larger
// entry up one slot in turn, set by the single write port of the entry memory.
// A read transfer makes one memory read per entry; an empty store answers in
// the cycle after the transfer. Results leave through an output register.
// Reset is synchronous and empties the store; the entry memory itself is not
// cleared. The result side cannot stall.
// ----------------------------------------------------------------------------
module top_k_tracker_min_heap import tkh_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic               req_command,
   input  logic [TAG_W-1:0]   req_title_tag,
   input  logic [COUNT_W-1:0] req_play_count,
   output logic               rsp_strobe,
   output logic               rsp_found,
   output logic [TAG_W-1:0]   rsp_out_tag,
   output logic [COUNT_W-1:0] rsp_out_count,
   output logic               rsp_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [KEEP_W-1:0]  csr_keep_count
);

   mem_req_type        mem_req;
   rsp_type            rsp;
   logic [KEY_W-1:0]   rd_data;

   logic               strobe_ff;
   logic               found_ff;
   logic [TAG_W-1:0]   tag_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               last_ff;

   tkh_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_command    (req_command),
      .req_title_tag  (req_title_tag),
      .req_play_count (req_play_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_keep_count (csr_keep_count),
      .rd_data        (rd_data),
      .mem_req        (mem_req),
      .rsp            (rsp)
   );

   tkh_ram #(
      .Depth     (CAPACITY),
      .Width     (KEY_W),
      .AddrWidth (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rd_data)
   );

   // register the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= rsp.valid;
      end
   end

   // register the result payload
   always_ff @(posedge clock) begin
      found_ff <= rsp.found;
      tag_ff   <= rsp.tag;
      count_ff <= rsp.count;
      last_ff  <= rsp.last;
   end

   assign rsp_strobe    = strobe_ff;
   assign rsp_found     = found_ff;
   assign rsp_out_tag   = tag_ff;
   assign rsp_out_count = count_ff;
   assign rsp_last      = last_ff;

endmodule

@@ hdl/tkh_checker.sv @@
// ----------------------------------------------------------------------------
// tkh_checker
// Port level checks of the top-k tracker, bound to the top level.
// ----------------------------------------------------------------------------
module tkh_checker import tkh_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               req_command,
   input logic               rsp_strobe,
   input logic               rsp_found,
   input logic [TAG_W-1:0]   rsp_out_tag,
   input logic [COUNT_W-1:0] rsp_out_count,
   input logic               rsp_last
);

   // an empty store answer is the whole readout
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> rsp_last)
      else $error("empty result not marked last");

   // an empty store answer carries no entry
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_found |-> (rsp_out_tag == '0) && (rsp_out_count == '0))
      else $error("empty result carries data");

   // a register transfer sets busy in the following cycle
   a_insert_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_REGISTER) |=> busy)
      else $error("register transfer did not start work");

   // a read transfer gives a result or starts a readout
   a_read_resp: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_command == CMD_READ) |=> rsp_strobe || busy)
      else $error("read transfer lost");

   // more results follow while the readout runs
   a_readout_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_found && !rsp_last |-> busy)
      else $error("readout ended before last result");

endmodule

bind top_k_tracker_min_heap tkh_checker u_tkh_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .req_command   (req_command),
   .rsp_strobe    (rsp_strobe),
   .rsp_found     (rsp_found),
   .rsp_out_tag   (rsp_out_tag),
   .rsp_out_count (rsp_out_count),
   .rsp_last      (rsp_last)
);
